// ----- hw/rtl/difference_pattern_hash_matcher_core_assert.svh -----
// ----------------------------------------------------------------------------
// Difference pattern hash matcher assertion macros
// Shorthand for the concurrent checks used in the matcher RTL.
// ----------------------------------------------------------------------------
`ifndef DIFFERENCE_PATTERN_HASH_MATCHER_CORE_ASSERT_SVH
`define DIFFERENCE_PATTERN_HASH_MATCHER_CORE_ASSERT_SVH

// Condition holds at every edge outside reset.
`define DPHM_ASSERT_ALWAYS(label, clk, rst, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Consequent holds in the same cycle as the antecedent.
`define DPHM_ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define DPHM_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/dphm_pkg.sv -----
// ----------------------------------------------------------------------------
// Difference pattern hash matcher package
// Widths, hash constants and the front stage item record.
// ----------------------------------------------------------------------------
package dphm_pkg;

  localparam int unsigned MAX_PATTERN = 1024;
  localparam int unsigned MAX_TEXT    = 1048576;

  localparam int unsigned FUNC_W   = 2;
  localparam int unsigned HEIGHT_W = 30;
  localparam int unsigned COUNT_W  = 21;
  localparam int unsigned LEN_W    = 11;
  localparam int unsigned HASH_W   = 30;
  localparam int unsigned RING_AW  = 10;
  localparam int unsigned RING_DEPTH = 1 << RING_AW;

  localparam int unsigned PATTERN_CAP = (MAX_PATTERN < RING_DEPTH) ? MAX_PATTERN : RING_DEPTH;
  localparam int unsigned COUNT_MAX   = (1 << COUNT_W) - 1;
  localparam int unsigned COUNT_CAP   = (MAX_TEXT < COUNT_MAX) ? MAX_TEXT : COUNT_MAX;

  localparam logic [63:0] HASH_MOD    = 64'd1000000033;
  localparam logic [63:0] DIFF_OFFSET = 64'd1000000010;
  localparam logic [63:0] HASH_BASE   = 64'd31;

  localparam logic [FUNC_W-1:0] FUNC_PATTERN = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_TEXT    = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_CLEAR   = 2'd2;

  typedef enum logic [1:0] {
    KIND_NONE,
    KIND_PATTERN,
    KIND_TEXT,
    KIND_CLEAR
  } kind_t;

  typedef struct packed {
    logic                valid;
    kind_t               kind;
    logic                pat_upd;
    logic                has_term;
    logic                full;
    logic                sub;
    logic                one;
    logic [HASH_W-1:0]   term;
    logic [RING_AW-1:0]  idx;
    logic [RING_AW-1:0]  pidx;
  } front_t;

endpackage

// ----- hw/rtl/dphm_in_if.sv -----
// ----------------------------------------------------------------------------
// Matcher input channel
// Valid/ready channel carrying one selector and height per item.
// ----------------------------------------------------------------------------
interface dphm_in_if import dphm_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [FUNC_W-1:0]   func;
  logic [HEIGHT_W-1:0] height;

  modport source (output valid, output func, output height, input ready);
  modport sink (input valid, input func, input height, output ready);
endinterface

// ----- hw/rtl/dphm_out_if.sv -----
// ----------------------------------------------------------------------------
// Matcher result channel
// Valid/ready channel carrying the match flag and running count.
// ----------------------------------------------------------------------------
interface dphm_out_if import dphm_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               match;
  logic [COUNT_W-1:0] match_count;

  modport source (output valid, output match, output match_count, input ready);
  modport sink (input valid, input match, input match_count, output ready);
endinterface

// ----- hw/rtl/dphm_front.sv -----
// ----------------------------------------------------------------------------
// Matcher front stage
// Input register, selector decode, neighbor difference terms and the
// pattern/text counters. Emits one decoded record per item.
// ----------------------------------------------------------------------------
module dphm_front import dphm_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  logic                valid,
  input  logic [FUNC_W-1:0]   func,
  input  logic [HEIGHT_W-1:0] height,
  output front_t              front
);

  logic                in_valid;
  logic [FUNC_W-1:0]   in_func;
  logic [HEIGHT_W-1:0] in_height;

  logic [LEN_W-1:0]    pattern_length, pattern_length_next;
  logic [HEIGHT_W-1:0] pattern_previous, pattern_previous_next;
  logic [HEIGHT_W-1:0] text_previous, text_previous_next;
  logic [COUNT_W-1:0]  text_seen, text_seen_next;
  logic [RING_AW-1:0]  ring_pointer, ring_pointer_next;
  logic [LEN_W-1:0]    span;
  front_t              front_next;

  function automatic logic [HASH_W-1:0] diff_term(logic [HEIGHT_W-1:0] now,
                                                  logic [HEIGHT_W-1:0] prev);
    logic [31:0] v;
    v = 32'(now) + 32'(DIFF_OFFSET + HASH_MOD) - 32'(prev);
    if (v >= 32'(2 * HASH_MOD)) v = v - 32'(2 * HASH_MOD);
    if (v >= 32'(HASH_MOD)) v = v - 32'(HASH_MOD);
    return v[HASH_W-1:0];
  endfunction

  always_comb begin
    span = (pattern_length == '0) ? '0 : pattern_length - LEN_W'(1);

    pattern_length_next   = pattern_length;
    pattern_previous_next = pattern_previous;
    text_previous_next    = text_previous;
    text_seen_next        = text_seen;
    ring_pointer_next     = ring_pointer;

    front_next       = '0;
    front_next.valid = in_valid;
    front_next.kind  = KIND_NONE;

    if (in_valid) begin
      unique case (in_func)
        FUNC_PATTERN: begin
          if (text_seen == '0 && pattern_length < LEN_W'(PATTERN_CAP)) begin
            front_next.kind    = KIND_PATTERN;
            front_next.pat_upd = (pattern_length != '0);
            front_next.term    = diff_term(in_height, pattern_previous);
            pattern_previous_next = in_height;
            pattern_length_next   = pattern_length + LEN_W'(1);
          end
        end
        FUNC_TEXT: begin
          front_next.kind     = KIND_TEXT;
          front_next.has_term = (text_seen != '0) && (span != '0);
          front_next.term     = diff_term(in_height, text_previous);
          front_next.full     = (pattern_length != '0) && (text_seen >= COUNT_W'(span));
          front_next.sub      = text_seen > COUNT_W'(span);
          front_next.one      = (pattern_length == LEN_W'(1));
          front_next.idx      = ring_pointer;
          front_next.pidx     = ring_pointer - span[RING_AW-1:0];
          text_previous_next  = in_height;
          if (text_seen < COUNT_W'(COUNT_CAP)) text_seen_next = text_seen + COUNT_W'(1);
          if (front_next.has_term) ring_pointer_next = ring_pointer + RING_AW'(1);
        end
        FUNC_CLEAR: begin
          front_next.kind       = KIND_CLEAR;
          pattern_length_next   = '0;
          pattern_previous_next = '0;
          text_previous_next    = '0;
          text_seen_next        = '0;
          ring_pointer_next     = '0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid         <= 1'b0;
      front            <= '0;
      pattern_length   <= '0;
      pattern_previous <= '0;
      text_previous    <= '0;
      text_seen        <= '0;
      ring_pointer     <= '0;
    end else if (en) begin
      in_valid         <= valid;
      front            <= front_next;
      pattern_length   <= pattern_length_next;
      pattern_previous <= pattern_previous_next;
      text_previous    <= text_previous_next;
      text_seen        <= text_seen_next;
      ring_pointer     <= ring_pointer_next;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      in_func   <= func;
      in_height <= height;
    end
  end

endmodule

// ----- hw/rtl/dphm_modmul.sv -----
// ----------------------------------------------------------------------------
// Matcher modular multiplier
// Four stage a*b mod p: product, Barrett quotient estimate, remainder,
// final correction.
// ----------------------------------------------------------------------------
module dphm_modmul import dphm_pkg::*; (
  input  logic              clk,
  input  logic              en,
  input  logic [HASH_W-1:0] a,
  input  logic [HASH_W-1:0] b,
  output logic [HASH_W-1:0] result
);

  localparam int unsigned PROD_W = 2 * HASH_W;
  localparam int unsigned QW     = HASH_W + 1;
  localparam logic [63:0] BARRETT_MU = (64'd1 << PROD_W) / HASH_MOD;

  logic [PROD_W-1:0] prod;
  logic [QW-1:0]     qest;
  logic [31:0]       prod_low;
  logic [31:0]       rem;
  logic [2*QW-1:0]   qmul;
  logic [31:0]       rem_next;
  logic [31:0]       rem_fix;

  always_comb begin
    qmul     = (2*QW)'(prod[PROD_W-1:HASH_W-1]) * (2*QW)'(BARRETT_MU);
    rem_next = prod_low - 32'((2*QW)'(qest) * (2*QW)'(HASH_MOD));
    if (rem >= 32'(2 * HASH_MOD)) begin
      rem_fix = rem - 32'(2 * HASH_MOD);
    end else if (rem >= 32'(HASH_MOD)) begin
      rem_fix = rem - 32'(HASH_MOD);
    end else begin
      rem_fix = rem;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod     <= PROD_W'(a) * PROD_W'(b);
      qest     <= qmul[2*QW-1:QW];
      prod_low <= prod[31:0];
      rem      <= rem_next;
      result   <= rem_fix[HASH_W-1:0];
    end
  end

endmodule

// ----- hw/rtl/difference_pattern_hash_matcher_core.sv -----
// ----------------------------------------------------------------------------
// Difference pattern hash matcher core
// Streams pattern heights, then text heights, and for every text item
// returns whether the window ending there has the pattern's difference
// shape (equal base-31 hashes mod 1000000033) plus the saturating match
// count. One item is accepted per clock while the result register is free
// or being taken; results pass the input, front, stage 2 to 6 and output
// registers. The per-item window compare uses prefix hashes: the prefix
// update (*31 + term) is combinational, and the prefix times 31^w product
// runs through a four stage Barrett multiplier feeding a 1024-entry ring
// with a write-to-read bypass. The ring needs no clearing pass after reset.
// ----------------------------------------------------------------------------
`include "difference_pattern_hash_matcher_core_assert.svh"

module difference_pattern_hash_matcher_core import dphm_pkg::*; (
  input logic        clk,
  input logic        rst,
  dphm_in_if.sink    items,
  dphm_out_if.source results
);

  localparam int unsigned RECIP_SHIFT = 20;
  localparam logic [63:0] RECIP_SMALL = (64'd1 << (2 * RECIP_SHIFT)) / HASH_MOD;

  typedef struct packed {
    logic               valid;
    logic               is_text;
    logic               is_clear;
    logic               has_term;
    logic               full;
    logic               sub;
    logic               one;
    logic [RING_AW-1:0] idx;
    logic [RING_AW-1:0] pidx;
    logic [HASH_W-1:0]  diff_hash;
  } item_t;

  logic en;
  front_t front;

  logic [HASH_W-1:0] pattern_hash, pattern_hash_next;
  logic [HASH_W-1:0] top_power, top_power_next;
  logic [HASH_W-1:0] prefix, prefix_next;

  item_t s2_item, s2_next;
  item_t s3_item, s3_next;
  item_t s4_item, s5_item, s6_item;

  logic [HASH_W-1:0] mm_result;
  logic [HASH_W-1:0] ring [RING_DEPTH];
  logic [HASH_W-1:0] ring_rd;
  logic              ring_we;
  logic [HASH_W-1:0] partner;
  logic              hit;

  logic [COUNT_W-1:0] found_count, found_count_next;
  logic               out_valid;
  logic               out_match;
  logic [COUNT_W-1:0] out_count;

  function automatic logic [HASH_W-1:0] mod_small(logic [35:0] x);
    logic [26:0] qmul;
    logic [6:0]  q;
    logic [35:0] r;
    qmul = 27'(x[35:RECIP_SHIFT]) * 27'(RECIP_SMALL);
    q    = qmul[26:RECIP_SHIFT];
    r    = x - 36'(q) * 36'(HASH_MOD);
    if (r >= 36'(HASH_MOD)) r = r - 36'(HASH_MOD);
    return r[HASH_W-1:0];
  endfunction

  function automatic logic [HASH_W-1:0] sub_mod(logic [HASH_W-1:0] a,
                                                logic [HASH_W-1:0] b);
    logic [HASH_W:0] d;
    d = {1'b0, a} - {1'b0, b};
    if (a < b) d = d + (HASH_W+1)'(HASH_MOD);
    return d[HASH_W-1:0];
  endfunction

  assign en = !out_valid || results.ready;
  assign items.ready = en;

  dphm_front u_front (
    .clk    (clk),
    .rst    (rst),
    .en     (en),
    .valid  (items.valid),
    .func   (items.func),
    .height (items.height),
    .front  (front)
  );

  // Hash state doubles as the stage 2 payload for the item that just passed.
  always_comb begin
    pattern_hash_next = pattern_hash;
    top_power_next    = top_power;
    prefix_next       = prefix;

    s2_next          = '0;
    s2_next.valid    = front.valid && (front.kind == KIND_TEXT || front.kind == KIND_CLEAR);
    s2_next.is_text  = (front.kind == KIND_TEXT);
    s2_next.is_clear = (front.kind == KIND_CLEAR);
    s2_next.has_term = front.has_term;
    s2_next.full     = front.full;
    s2_next.sub      = front.sub;
    s2_next.one      = front.one;
    s2_next.idx      = front.idx;
    s2_next.pidx     = front.pidx;

    if (front.valid) begin
      unique case (front.kind)
        KIND_PATTERN: begin
          if (front.pat_upd) begin
            pattern_hash_next = mod_small(36'(pattern_hash) * 36'(HASH_BASE) + 36'(front.term));
            top_power_next    = mod_small(36'(top_power) * 36'(HASH_BASE));
          end
        end
        KIND_TEXT: begin
          if (front.has_term) begin
            prefix_next = mod_small(36'(prefix) * 36'(HASH_BASE) + 36'(front.term));
          end
        end
        KIND_CLEAR: begin
          pattern_hash_next = '0;
          top_power_next    = HASH_W'(1);
          prefix_next       = '0;
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    s3_next           = s2_item;
    s3_next.diff_hash = sub_mod(prefix, pattern_hash);
  end

  dphm_modmul u_modmul (
    .clk    (clk),
    .en     (en),
    .a      (prefix),
    .b      (top_power),
    .result (mm_result)
  );

  assign ring_we = en && s6_item.valid && s6_item.has_term;

  always_ff @(posedge clk) begin
    if (ring_we) ring[s6_item.idx] <= mm_result;
    if (en) begin
      if (ring_we && s6_item.idx == s5_item.pidx) begin
        ring_rd <= mm_result;
      end else begin
        ring_rd <= ring[s5_item.pidx];
      end
    end
  end

  always_comb begin
    partner = s6_item.sub ? ring_rd : '0;
    hit     = s6_item.has_term ? (s6_item.full && s6_item.diff_hash == partner)
                               : s6_item.one;
    found_count_next = found_count;
    if (s6_item.valid) begin
      if (s6_item.is_clear) begin
        found_count_next = '0;
      end else if (s6_item.is_text && hit && found_count < COUNT_W'(COUNT_CAP)) begin
        found_count_next = found_count + COUNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_hash <= '0;
      top_power    <= HASH_W'(1);
      prefix       <= '0;
      s2_item      <= '0;
      s3_item      <= '0;
      s4_item      <= '0;
      s5_item      <= '0;
      s6_item      <= '0;
      found_count  <= '0;
      out_valid    <= 1'b0;
    end else if (en) begin
      pattern_hash <= pattern_hash_next;
      top_power    <= top_power_next;
      prefix       <= prefix_next;
      s2_item      <= s2_next;
      s3_item      <= s3_next;
      s4_item      <= s3_item;
      s5_item      <= s4_item;
      s6_item      <= s5_item;
      found_count  <= found_count_next;
      out_valid    <= s6_item.valid && s6_item.is_text;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_match <= hit;
      out_count <= found_count_next;
    end
  end

  assign results.valid       = out_valid;
  assign results.match       = out_match;
  assign results.match_count = out_count;

  `DPHM_ASSERT_NEXT(a_count_step, clk, rst, en && s6_item.valid && s6_item.is_text, found_count == $past(found_count) || found_count == $past(found_count) + COUNT_W'(1), "match count moved by more than one")
  `DPHM_ASSERT_IMPLIES(a_match_counted, clk, rst, results.valid && results.match, results.match_count != '0, "match reported with zero count")
  `DPHM_ASSERT_IMPLIES(a_ring_range, clk, rst, s6_item.valid && s6_item.has_term, mm_result < HASH_W'(HASH_MOD), "ring term not reduced")
  `DPHM_ASSERT_ALWAYS(a_hash_range, clk, rst, prefix < HASH_W'(HASH_MOD) && pattern_hash < HASH_W'(HASH_MOD) && top_power < HASH_W'(HASH_MOD), "hash state not reduced")

endmodule
